FILE: rtl/core/yuv2rgb_pkg.sv
`default_nettype none

package yuv2rgb_pkg;

  // Byte order codes for the configuration register
  localparam logic ORDER_YUYV = 1'b0;
  localparam logic ORDER_UYVY = 1'b1;

  localparam int SUM_W = 22;

  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;

  localparam logic signed [SUM_W-1:0] COEF_Y    = 22'sd1164;
  localparam logic signed [SUM_W-1:0] COEF_R_CR = 22'sd1596;
  localparam logic signed [SUM_W-1:0] COEF_G_CB = 22'sd392;
  localparam logic signed [SUM_W-1:0] COEF_G_CR = 22'sd813;
  localparam logic signed [SUM_W-1:0] COEF_B_CB = 22'sd2017;

  localparam logic signed [SUM_W-1:0] SUM_FLOOR = 22'sd999;
  localparam logic signed [SUM_W-1:0] SUM_SAT   = 22'sd256000;
  // ceil(2^28 / 1000): exact floor quotient for sums below 256000
  localparam logic [18:0]             RECIP_1000 = 19'd268436;
  localparam logic [7:0]              CHAN_MAX   = 8'd255;
  localparam logic [7:0]              ALPHA_OPAQUE = 8'd255;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
  } yuv2rgb_in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic [7:0] alpha_value;
  } yuv2rgb_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } yuv2rgb_rgb_t;

endpackage

`default_nettype wire

FILE: rtl/core/yuv2rgb_pixel.sv
`default_nettype none

module yuv2rgb_pixel
  import yuv2rgb_pkg::*;
(
  input  wire logic signed [8:0] luma,
  input  wire logic signed [8:0] cb,
  input  wire logic signed [8:0] cr,
  output yuv2rgb_rgb_t           rgb
);

  // Raise to 999, divide by 1000, cap at 255
  function automatic logic [7:0] scale_clamp(input logic signed [SUM_W-1:0] sum);
    logic [17:0] v;
    logic [36:0] prod;
    logic [7:0]  q;
    v    = sum[17:0];
    prod = {19'd0, v} * {18'd0, RECIP_1000};
    if (sum < SUM_FLOOR) begin
      q = 8'd0;
    end else if (sum >= SUM_SAT) begin
      q = CHAN_MAX;
    end else begin
      q = prod[35:28];
    end
    return q;
  endfunction

  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] cb_w;
  logic signed [SUM_W-1:0] cr_w;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;

  always_comb begin
    cb_w  = SUM_W'(cb);
    cr_w  = SUM_W'(cr);
    base  = COEF_Y * SUM_W'(luma);
    sum_r = base + COEF_R_CR * cr_w;
    sum_g = base - COEF_G_CB * cb_w - COEF_G_CR * cr_w;
    sum_b = base + COEF_B_CB * cb_w;
    rgb.red   = scale_clamp(sum_r);
    rgb.green = scale_clamp(sum_g);
    rgb.blue  = scale_clamp(sum_b);
  end

endmodule

`default_nettype wire

FILE: rtl/core/yuv422_to_rgba_converter.sv
`default_nettype none
// YUV 4:2:2 macropixel to two RGBA pixels, BT.601.
// Path from input beat to result beat: input register, then result register.
// Throughput: one macropixel per cycle while out_ready holds; the combinational conversion between the
// input and result registers allows that rate.
// Reset: synchronous; clears both valid flags and sets byte_order to YUYV.

module yuv422_to_rgba_converter
  import yuv2rgb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire yuv2rgb_in_t  in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output yuv2rgb_out_t      out_data
);

  logic         byte_order;
  logic         s1_valid;
  yuv2rgb_in_t  s1_data;
  logic         s2_load;

  logic [7:0]        y0_raw, y1_raw, cb_raw, cr_raw;
  logic signed [8:0] y0, y1, cb, cr;
  yuv2rgb_rgb_t      rgb_first, rgb_second;
  yuv2rgb_out_t      result;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order <= ORDER_YUYV;
    end else if (cfg_wr_en) begin
      byte_order <= cfg_wr_data;
    end
  end

  // Result register takes a beat when empty or being drained
  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    case (byte_order)
      ORDER_UYVY: begin
        cb_raw = s1_data.byte_a;
        y0_raw = s1_data.byte_b;
        cr_raw = s1_data.byte_c;
        y1_raw = s1_data.byte_d;
      end
      default: begin
        y0_raw = s1_data.byte_a;
        cb_raw = s1_data.byte_b;
        y1_raw = s1_data.byte_c;
        cr_raw = s1_data.byte_d;
      end
    endcase
    y0 = $signed({1'b0, y0_raw}) - $signed({1'b0, LUMA_OFFSET});
    y1 = $signed({1'b0, y1_raw}) - $signed({1'b0, LUMA_OFFSET});
    cb = $signed({1'b0, cb_raw}) - $signed({1'b0, CHROMA_OFFSET});
    cr = $signed({1'b0, cr_raw}) - $signed({1'b0, CHROMA_OFFSET});
  end

  yuv2rgb_pixel u_pixel_first (
    .luma (y0),
    .cb   (cb),
    .cr   (cr),
    .rgb  (rgb_first)
  );

  yuv2rgb_pixel u_pixel_second (
    .luma (y1),
    .cb   (cb),
    .cr   (cr),
    .rgb  (rgb_second)
  );

  always_comb begin
    result.red_first    = rgb_first.red;
    result.green_first  = rgb_first.green;
    result.blue_first   = rgb_first.blue;
    result.red_second   = rgb_second.red;
    result.green_second = rgb_second.green;
    result.blue_second  = rgb_second.blue;
    result.alpha_value  = ALPHA_OPAQUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

FILE: test/yuv422_to_rgba_converter_tb.sv
`timescale 1ns / 100ps

module yuv422_to_rgba_converter_tb;
  import yuv2rgb_pkg::*;

  localparam int RANDOM_BEATS = 1400;
  localparam int DRAIN_CYCLES = 8;

  localparam int Y_BIAS    = 16;
  localparam int C_BIAS    = 128;
  localparam int K_Y       = 1164;
  localparam int K_R_CR    = 1596;
  localparam int K_G_CB    = 392;
  localparam int K_G_CR    = 813;
  localparam int K_B_CB    = 2017;
  localparam int SUM_MIN   = 999;
  localparam int SCALE_DIV = 1000;
  localparam int LEVEL_MAX = 255;
  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  logic         clk;
  logic         rst;
  logic         cfg_wr_en;
  logic         cfg_wr_data;
  logic         in_valid;
  logic         in_ready;
  yuv2rgb_in_t  in_data;
  logic         out_valid;
  logic         out_ready;
  yuv2rgb_out_t out_data;

  yuv2rgb_out_t expected_rgba[$];
  logic         order_shadow;
  bit           idle_on;
  int           mismatch_count;
  int           stall_left;
  yuv2rgb_out_t rgba_want;

  yuv422_to_rgba_converter u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // scaled sum -> 8-bit level: raise to the floor, divide, saturate
  function automatic logic [7:0] scale_to_level(int sum);
    int v;
    v = (sum < SUM_MIN) ? SUM_MIN : sum;
    v = v / SCALE_DIV;
    if (v > LEVEL_MAX) begin
      v = LEVEL_MAX;
    end
    return v[7:0];
  endfunction

  function automatic yuv2rgb_out_t predict_rgba(yuv2rgb_in_t px, logic order);
    int y0;
    int y1;
    int cb;
    int cr;
    yuv2rgb_out_t res;
    if (order == ORDER_UYVY) begin
      cb = px.byte_a;
      y0 = px.byte_b;
      cr = px.byte_c;
      y1 = px.byte_d;
    end else begin
      y0 = px.byte_a;
      cb = px.byte_b;
      y1 = px.byte_c;
      cr = px.byte_d;
    end
    y0 -= Y_BIAS;
    y1 -= Y_BIAS;
    cb -= C_BIAS;
    cr -= C_BIAS;
    res.red_first    = scale_to_level(K_Y * y0 + K_R_CR * cr);
    res.green_first  = scale_to_level(K_Y * y0 - K_G_CB * cb - K_G_CR * cr);
    res.blue_first   = scale_to_level(K_Y * y0 + K_B_CB * cb);
    res.red_second   = scale_to_level(K_Y * y1 + K_R_CR * cr);
    res.green_second = scale_to_level(K_Y * y1 - K_G_CB * cb - K_G_CR * cr);
    res.blue_second  = scale_to_level(K_Y * y1 + K_B_CB * cb);
    res.alpha_value  = ALPHA_FULL;
    return res;
  endfunction

  // mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 24);
  endfunction

  // lean toward black/white levels, chroma center and the rails
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(10, 22));
      3: return 8'($urandom_range(120, 136));
      4: return 8'($urandom_range(228, 242));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] corner_word(int k);
    case (k)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1080_1080;  // black
      3: return 32'hEB80_EB80;  // white, just under full scale
      4: return 32'h1180_1180;  // one step above the floor
      5: return 32'h0F80_0F80;  // luma below black
      6: return 32'hFF00_FFFF;
      7: return 32'h00FF_00FF;
      8: return 32'hFFFF_00FF;
      default: return 32'h10FF_EB00;  // lumas differ across the pair
    endcase
  endfunction

  task automatic send_macropixel(yuv2rgb_in_t px);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_rgba.push_back(predict_rgba(px, order_shadow));
  endtask

  // write only with the pipe empty
  task automatic set_byte_order(logic order);
    in_valid <= 1'b0;
    while (expected_rgba.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    order_shadow = order;
  endtask

  task automatic check_level(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic test_reset_default_order();
    for (int k = 0; k < 10; k++) begin
      send_macropixel(yuv2rgb_in_t'(corner_word(k)));
    end
  endtask

  task automatic test_uyvy_order();
    set_byte_order(ORDER_UYVY);
    for (int k = 0; k < 10; k++) begin
      send_macropixel(yuv2rgb_in_t'(corner_word(k)));
    end
  endtask

  task automatic test_yuyv_restore();
    set_byte_order(ORDER_YUYV);
    for (int k = 2; k < 5; k++) begin
      send_macropixel(yuv2rgb_in_t'(corner_word(k)));
    end
  endtask

  task automatic test_random_stream();
    int sent;
    int burst;
    yuv2rgb_in_t px;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      set_byte_order(logic'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(60, 250);
      if (burst > RANDOM_BEATS - sent) begin
        burst = RANDOM_BEATS - sent;
      end
      for (int k = 0; k < burst; k++) begin
        px.byte_a = pick_byte();
        px.byte_b = pick_byte();
        px.byte_c = pick_byte();
        px.byte_d = pick_byte();
        send_macropixel(px);
      end
      sent += burst;
    end
    idle_on = 1'b1;
  endtask

  // receiver: random stalls, some long; no new stall starts while idling is off
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_rgba.size() == 0) begin
        $error("result beat with no pending macropixel");
        mismatch_count++;
      end else begin
        rgba_want = expected_rgba.pop_front();
        check_level("red_first", rgba_want.red_first, out_data.red_first);
        check_level("green_first", rgba_want.green_first, out_data.green_first);
        check_level("blue_first", rgba_want.blue_first, out_data.blue_first);
        check_level("red_second", rgba_want.red_second, out_data.red_second);
        check_level("green_second", rgba_want.green_second, out_data.green_second);
        check_level("blue_second", rgba_want.blue_second, out_data.blue_second);
        check_level("alpha_value", rgba_want.alpha_value, out_data.alpha_value);
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    out_ready      <= 1'b0;
    stall_left     = 0;
    order_shadow   = ORDER_YUYV;
    idle_on        = 1'b1;
    mismatch_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_default_order();
    test_uyvy_order();
    test_yuyv_restore();
    test_random_stream();

    in_valid <= 1'b0;
    while (expected_rgba.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
